// File: hdl/sobel_pkg.sv
// Shared types and constants for the 3x3 Sobel gradient block.
`timescale 1ns / 1ps

package sobel_pkg;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int POS_W  = 11;
    localparam int CFG_W  = 12;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // pending result slots of one pixel, in emission order
    localparam int EMIT_UL = 0;
    localparam int EMIT_UR = 1;
    localparam int EMIT_LL = 2;
    localparam int EMIT_LR = 3;
    localparam int EMIT_N  = 4;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [2:0][2:0] grid_t;
    typedef logic signed [GRAD_W-1:0] grad_t;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic use_last_row;
        logic use_last_col;
    } tap_sel_t;

endpackage

// File: hdl/sobel_if.sv
// Stream interfaces for pixel and gradient beats.
`timescale 1ns / 1ps

interface sobel_pix_if;
    logic                      valid;
    logic                      ready;
    logic [sobel_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface sobel_grad_if;
    logic                               valid;
    logic                               ready;
    logic signed [sobel_pkg::GRAD_W-1:0] grad_x;
    logic signed [sobel_pkg::GRAD_W-1:0] grad_y;
    logic [sobel_pkg::POS_W-1:0]         out_row;
    logic [sobel_pkg::POS_W-1:0]         out_col;
    logic                               last_of_run;
    logic                               end_of_frame;

    modport source (output valid, output grad_x, output grad_y, output out_row,
                    output out_col, output last_of_run, output end_of_frame,
                    input ready);
    modport sink (input valid, input grad_x, input grad_y, input out_row,
                  input out_col, input last_of_run, input end_of_frame,
                  output ready);
endinterface

// File: hdl/sobel_linebuf.sv
// Two line stores with registered read and same-address write bypass.
`timescale 1ns / 1ps

module sobel_linebuf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  sobel_pkg::pix_t     wr_older,
    input  sobel_pkg::pix_t     wr_newer,
    output sobel_pkg::pix_t     older,
    output sobel_pkg::pix_t     newer
);

    sobel_pkg::pix_t older_mem [DEPTH];
    sobel_pkg::pix_t newer_mem [DEPTH];
    sobel_pkg::pix_t older_q_reg;
    sobel_pkg::pix_t newer_q_reg;
    sobel_pkg::pix_t byp_older_reg;
    sobel_pkg::pix_t byp_newer_reg;
    logic            byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            older_q_reg   <= older_mem[rd_addr];
            newer_q_reg   <= newer_mem[rd_addr];
            byp_older_reg <= wr_older;
            byp_newer_reg <= wr_newer;
        end
    end

    // read and write of one entry at the same edge: take the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign older = byp_reg ? byp_older_reg : older_q_reg;
    assign newer = byp_reg ? byp_newer_reg : newer_q_reg;

endmodule

// File: hdl/sobel_kernel.sv
// Edge-replicating tap selection and Sobel x/y sums over a 3x3 grid.
`timescale 1ns / 1ps

module sobel_kernel (
    input  sobel_pkg::grid_t     grid,
    input  sobel_pkg::tap_sel_t  sel,
    output sobel_pkg::grad_t     grad_x,
    output sobel_pkg::grad_t     grad_y
);

    logic [1:0]        rs [3];
    logic [1:0]        cs [3];
    sobel_pkg::grad_t  p [3][3];

    always_comb
    begin
        if (sel.use_last_row)
        begin
            rs[0] = sel.row_ge1 ? 2'd1 : 2'd2;
            rs[1] = 2'd2;
        end
        else
        begin
            rs[0] = sel.row_ge2 ? 2'd0 : 2'd1;
            rs[1] = 2'd1;
        end
        rs[2] = 2'd2;
        if (sel.use_last_col)
        begin
            cs[0] = sel.col_ge1 ? 2'd1 : 2'd2;
            cs[1] = 2'd2;
        end
        else
        begin
            cs[0] = sel.col_ge2 ? 2'd0 : 2'd1;
            cs[1] = 2'd1;
        end
        cs[2] = 2'd2;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[i][k] = $signed({3'b000, grid[rs[i]][cs[k]]});
            end
        end
    end

    assign grad_x = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1)
                  + (p[2][2] - p[2][0]);
    assign grad_y = (p[2][0] + (p[2][1] <<< 1) + p[2][2])
                  - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);

endmodule

// File: hdl/sobel_gradient_3x3_replicate.sv
// Top level: streaming 3x3 Sobel gradients with replicated borders.
// A pixel's first result goes from the stage 1 register to the output register once it is free.
// Throughput: one pixel per cycle while the output register is free; a pixel that completes
// k > 1 results (last column/row) holds the input, one output register write per result.
// Reset: size registers to 640 x 480, position counters and all valid flags cleared;
// line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module sobel_gradient_3x3_replicate #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sobel_pkg::APB_AW-1:0]     paddr,
    input  logic [sobel_pkg::APB_DW-1:0]     pwdata,
    output logic [sobel_pkg::APB_DW-1:0]     prdata,
    output logic                             pready,
    sobel_pix_if.sink                        pixels,
    sobel_grad_if.source                     gradients
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CMPWC = (CW + 1 > sobel_pkg::CFG_W) ? CW + 1 : sobel_pkg::CFG_W;
    localparam int CMPWR = (RW + 1 > sobel_pkg::CFG_W) ? RW + 1 : sobel_pkg::CFG_W;
    localparam logic [CW-1:0] W_LAST_MAX = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0] H_LAST_MAX = RW'(MAX_HEIGHT - 1);

    logic [sobel_pkg::CFG_W-1:0] width_reg;
    logic [sobel_pkg::CFG_W-1:0] height_reg;
    logic                        cfg_wr;

    logic [CMPWC-1:0] wv;
    logic [CMPWR-1:0] hv;
    logic [CW-1:0]    w_last;
    logic [RW-1:0]    h_last;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic                          s1_valid_reg;
    logic [sobel_pkg::EMIT_N-1:0]  s1_pend_reg;
    sobel_pkg::pix_t               s1_pix_reg;
    logic [CW-1:0]                 s1_col_reg;
    logic [RW-1:0]                 s1_row_reg;
    sobel_pkg::pix_t [2:0][1:0]    win_reg;

    logic                          out_valid_reg;
    sobel_pkg::grad_t              out_gx_reg;
    sobel_pkg::grad_t              out_gy_reg;
    logic [sobel_pkg::POS_W-1:0]   out_row_reg;
    logic [sobel_pkg::POS_W-1:0]   out_col_reg;
    logic                          out_last_reg;
    logic                          out_eof_reg;

    logic                          accept;
    logic                          in_ready;
    logic                          out_free;
    logic                          load;
    logic                          retire;
    logic                          last_col;
    logic                          last_row;
    logic [sobel_pkg::EMIT_N-1:0]  pend_in;
    logic [sobel_pkg::EMIT_N-1:0]  pick;
    logic [sobel_pkg::EMIT_N-1:0]  pend_after;
    sobel_pkg::pix_t               older;
    sobel_pkg::pix_t               newer;
    sobel_pkg::grid_t              grid;
    sobel_pkg::tap_sel_t           sel;
    sobel_pkg::grad_t              gx;
    sobel_pkg::grad_t              gy;
    logic [CW-1:0]                 res_col;
    logic [RW-1:0]                 res_row;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            sobel_pkg::REG_IMAGE_WIDTH:  prdata = sobel_pkg::APB_DW'(width_reg);
            sobel_pkg::REG_IMAGE_HEIGHT: prdata = sobel_pkg::APB_DW'(height_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sobel_pkg::CFG_W'(640);
            height_reg <= sobel_pkg::CFG_W'(480);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                sobel_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[sobel_pkg::CFG_W-1:0];
                sobel_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[sobel_pkg::CFG_W-1:0];
                default:                     width_reg  <= width_reg;
            endcase
        end
    end

    // frame size clamped to 1..MAX
    assign wv = CMPWC'(width_reg);
    assign hv = CMPWR'(height_reg);

    always_comb
    begin
        priority if (wv == '0)
            w_last = '0;
        else if (wv > CMPWC'(MAX_WIDTH))
            w_last = W_LAST_MAX;
        else
            w_last = CW'(wv - CMPWC'(1));
        priority if (hv == '0)
            h_last = '0;
        else if (hv > CMPWR'(MAX_HEIGHT))
            h_last = H_LAST_MAX;
        else
            h_last = RW'(hv - CMPWR'(1));
    end

    // handshake
    assign out_free   = !out_valid_reg || gradients.ready;
    assign pick       = s1_pend_reg & (~s1_pend_reg + sobel_pkg::EMIT_N'(1));
    assign pend_after = s1_pend_reg & ~pick;
    assign load       = s1_valid_reg && (s1_pend_reg != '0) && out_free;
    assign retire     = s1_valid_reg && ((s1_pend_reg == '0) || (load && pend_after == '0));
    assign in_ready   = !s1_valid_reg || retire;
    assign accept     = pixels.valid && in_ready;
    assign pixels.ready = in_ready;

    assign last_col = (col_reg == w_last);
    assign last_row = (row_reg == h_last);

    always_comb
    begin
        pend_in = '0;
        pend_in[sobel_pkg::EMIT_UL] = (row_reg != '0) && (col_reg != '0);
        pend_in[sobel_pkg::EMIT_UR] = (row_reg != '0) && last_col;
        pend_in[sobel_pkg::EMIT_LL] = last_row && (col_reg != '0);
        pend_in[sobel_pkg::EMIT_LR] = last_row && last_col;
    end

    // position of the next pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // stage 1: pixel in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_pend_reg  <= pend_in;
        end
        else
        begin
            if (retire)
                s1_valid_reg <= 1'b0;
            if (load)
                s1_pend_reg <= pend_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixels.pixel;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    sobel_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_linebuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (col_reg),
        .wr_en    (retire),
        .wr_addr  (s1_col_reg),
        .wr_older (newer),
        .wr_newer (s1_pix_reg),
        .older    (older),
        .newer    (newer)
    );

    always_comb
    begin
        grid[0][0] = win_reg[0][0];
        grid[0][1] = win_reg[0][1];
        grid[0][2] = older;
        grid[1][0] = win_reg[1][0];
        grid[1][1] = win_reg[1][1];
        grid[1][2] = newer;
        grid[2][0] = win_reg[2][0];
        grid[2][1] = win_reg[2][1];
        grid[2][2] = s1_pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= grid[i][1];
                win_reg[i][1] <= grid[i][2];
            end
        end
    end

    assign sel.row_ge1      = (s1_row_reg != '0);
    assign sel.row_ge2      = (s1_row_reg > RW'(1));
    assign sel.col_ge1      = (s1_col_reg != '0);
    assign sel.col_ge2      = (s1_col_reg > CW'(1));
    assign sel.use_last_row = pick[sobel_pkg::EMIT_LL] || pick[sobel_pkg::EMIT_LR];
    assign sel.use_last_col = pick[sobel_pkg::EMIT_UR] || pick[sobel_pkg::EMIT_LR];

    sobel_kernel u_kernel (
        .grid   (grid),
        .sel    (sel),
        .grad_x (gx),
        .grad_y (gy)
    );

    assign res_row = sel.use_last_row ? s1_row_reg : s1_row_reg - RW'(1);
    assign res_col = sel.use_last_col ? s1_col_reg : s1_col_reg - CW'(1);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (gradients.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_gx_reg   <= gx;
            out_gy_reg   <= gy;
            out_row_reg  <= sobel_pkg::POS_W'(res_row);
            out_col_reg  <= sobel_pkg::POS_W'(res_col);
            out_last_reg <= (pend_after == '0);
            out_eof_reg  <= pick[sobel_pkg::EMIT_LR];
        end
    end

    assign gradients.valid        = out_valid_reg;
    assign gradients.grad_x       = out_gx_reg;
    assign gradients.grad_y       = out_gy_reg;
    assign gradients.out_row      = out_row_reg;
    assign gradients.out_col      = out_col_reg;
    assign gradients.last_of_run  = out_last_reg;
    assign gradients.end_of_frame = out_eof_reg;

endmodule

// File: test/sobel_gradient_checker.sv
// Checker for the Sobel gradient block: predicts gradient beats from accepted pixels.
`timescale 1ns / 1ps

module sobel_gradient_checker
    import sobel_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    sobel_pix_if              pixels,
    sobel_grad_if             gradients,
    output int                mismatch_count,
    output int                pending_beats,
    output int                checked_beats
);

    localparam int unsigned FRAME_MAX    = 2048;
    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic                     run_last;
        logic                     eof;
    } grad_beat_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_t             older_row [FRAME_MAX];
    pix_t             newer_row [FRAME_MAX];
    pix_t             win [3][2];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int               nb [3][3];
    grad_beat_t       grad_expected_q [$];
    grad_beat_t       want;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // neighbourhood rows {r0, r1, 2} and columns {c0, c1, 2} of nb
    function automatic grad_beat_t sobel_at(int r0, int r1, int c0, int c1,
                                            int unsigned r, int unsigned c, logic eof);
        grad_beat_t b;
        int rs [3];
        int cs [3];
        int gx;
        int gy;
        rs = '{r0, r1, 2};
        cs = '{c0, c1, 2};
        gx = (nb[rs[0]][cs[2]] - nb[rs[0]][cs[0]])
           + 2 * (nb[rs[1]][cs[2]] - nb[rs[1]][cs[0]])
           + (nb[rs[2]][cs[2]] - nb[rs[2]][cs[0]]);
        gy = (nb[rs[2]][cs[0]] + 2 * nb[rs[2]][cs[1]] + nb[rs[2]][cs[2]])
           - (nb[rs[0]][cs[0]] + 2 * nb[rs[0]][cs[1]] + nb[rs[0]][cs[2]]);
        b.gx       = gx[GRAD_W-1:0];
        b.gy       = gy[GRAD_W-1:0];
        b.row      = r[POS_W-1:0];
        b.col      = c[POS_W-1:0];
        b.run_last = 1'b0;
        b.eof      = eof;
        return b;
    endfunction

    task automatic predict_gradients(input pix_t p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        bit          last_col;
        bit          last_row;
        int          rp;
        int          rl;
        int          cp;
        int          cl;
        grad_beat_t  burst [$];
        w = clamp_dim(width_reg, FRAME_MAX);
        h = clamp_dim(height_reg, FRAME_MAX);
        c = col_pos;
        r = row_pos;
        if (c >= w)
            c = w - 1;
        if (r >= h)
            r = h - 1;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        for (int i = 0; i < 3; i++)
        begin
            nb[i][0] = win[i][0];
            nb[i][1] = win[i][1];
        end
        nb[0][2] = older_row[c];
        nb[1][2] = newer_row[c];
        nb[2][2] = p;
        // missing rows and columns fall back to the replicated edge
        rp = (r >= 2) ? 0 : 1;
        rl = (r >= 1) ? 1 : 2;
        cp = (c >= 2) ? 0 : 1;
        cl = (c >= 1) ? 1 : 2;
        if (r >= 1)
        begin
            if (c >= 1)
                burst.push_back(sobel_at(rp, 1, cp, 1, r - 1, c - 1, 1'b0));
            if (last_col)
                burst.push_back(sobel_at(rp, 1, cl, 2, r - 1, c, 1'b0));
        end
        if (last_row)
        begin
            if (c >= 1)
                burst.push_back(sobel_at(rl, 2, cp, 1, r, c - 1, 1'b0));
            if (last_col)
                burst.push_back(sobel_at(rl, 2, cl, 2, r, c, 1'b1));
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[i])
            grad_expected_q.push_back(burst[i]);
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = nb[i][1];
            win[i][1] = nb[i][2];
        end
        older_row[c] = newer_row[c];
        newer_row[c] = p;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] exp_v,
                               input logic [POS_W-1:0] act_v, input bit is_signed);
        if (act_v !== exp_v)
        begin
            mismatch_count++;
            if (is_signed)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, $signed(exp_v), $signed(act_v));
            else
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            col_pos    = 0;
            row_pos    = 0;
            for (int i = 0; i < FRAME_MAX; i++)
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                win[i][0] = '0;
                win[i][1] = '0;
            end
            grad_expected_q.delete();
            mismatch_count = 0;
            checked_beats  = 0;
            pending_beats <= 0;
        end
        else
        begin
            if (gradients.valid && gradients.ready)
            begin
                checked_beats++;
                if (grad_expected_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, actual row %0d col %0d",
                             $time, gradients.out_row, gradients.out_col);
                end
                else
                begin
                    want = grad_expected_q.pop_front();
                    check_field("grad_x", want.gx, gradients.grad_x, 1'b1);
                    check_field("grad_y", want.gy, gradients.grad_y, 1'b1);
                    check_field("out_row", want.row, gradients.out_row, 1'b0);
                    check_field("out_col", want.col, gradients.out_col, 1'b0);
                    check_field("last_of_run", POS_W'(want.run_last),
                                POS_W'(gradients.last_of_run), 1'b0);
                    check_field("end_of_frame", POS_W'(want.eof),
                                POS_W'(gradients.end_of_frame), 1'b0);
                end
            end
            if (pixels.valid && pixels.ready)
                predict_gradients(pixels.pixel);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_IMAGE_WIDTH)
                    width_reg = pwdata[CFG_W-1:0];
                else
                    height_reg = pwdata[CFG_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            pending_beats <= grad_expected_q.size();
        end
    end

endmodule

// File: test/testbench.sv
// Testbench top: pixel frames, size register writes and the verdict for the Sobel block.
`timescale 1ns / 1ps

module testbench;
    import sobel_pkg::*;

    localparam int unsigned FRAME_MAX    = 2048;
    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;

    typedef enum {PAT_RANDOM, PAT_FLAT, PAT_COL_STEP, PAT_ROW_STEP} pattern_e;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int send_idle_pct;
    int recv_idle_pct;
    int pixels_sent;
    int settings_used;
    int mismatch_count;
    int pending_beats;
    int checked_beats;

    sobel_pix_if  pix_ch ();
    sobel_grad_if grad_ch ();

    sobel_gradient_3x3_replicate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pixels    (pix_ch),
        .gradients (grad_ch)
    );

    sobel_gradient_checker grad_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pixels         (pix_ch),
        .gradients      (grad_ch),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats),
        .checked_beats  (checked_beats)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
        grad_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic int eff_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > FRAME_MAX)
            return FRAME_MAX;
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(input int typical);
        case ($urandom_range(0, 19))
            0: return '0;
            1: return CFG_W'($urandom_range(FRAME_MAX + 1, 4095));
            default: return CFG_W'($urandom_range(1, typical));
        endcase
    endfunction

    task automatic send_pixel(input pix_t v);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= v;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        pixels_sent++;
    endtask

    task automatic hold_until_drained();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[CFG_W-1:0] = value;
        hold_until_drained();
        // a pixel without results still retires in the cycle after it is taken
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic stream_pixels(input int count, input pattern_e pat, input bit inv,
                                 input pix_t flat_v, input int ew, input int eh);
        int   col;
        int   row;
        pix_t v;
        col = 0;
        row = 0;
        for (int n = 0; n < count; n++)
        begin
            case (pat)
                PAT_FLAT:     v = flat_v;
                PAT_COL_STEP: v = (col >= ew / 2) ? 8'hFF : 8'h00;
                PAT_ROW_STEP: v = (row >= eh / 2) ? 8'hFF : 8'h00;
                default:      v = pix_t'($urandom_range(0, 255));
            endcase
            if (inv)
                v = ~v;
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
            send_pixel(v);
            col++;
            if (col == ew)
            begin
                col = 0;
                row = (row + 1 == eh) ? 0 : row + 1;
            end
        end
    endtask

    task automatic run_frame(input logic [CFG_W-1:0] wr, input logic [CFG_W-1:0] hr,
                             input int count, input pattern_e pat, input bit inv,
                             input pix_t flat_v);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_IMAGE_WIDTH, wr);
            write_reg(REG_IMAGE_HEIGHT, hr);
        end
        else
        begin
            write_reg(REG_IMAGE_HEIGHT, hr);
            write_reg(REG_IMAGE_WIDTH, wr);
        end
        settings_used++;
        stream_pixels(count, pat, inv, flat_v, eff_dim(wr), eff_dim(hr));
    endtask

    // whole frames, frames running into the next, and abandoned frames
    task automatic random_frames(input int n_items);
        int               stop_at;
        int               area;
        int               count;
        logic [CFG_W-1:0] wr;
        logic [CFG_W-1:0] hr;
        pattern_e         pat;
        stop_at = pixels_sent + n_items;
        while (pixels_sent < stop_at)
        begin
            wr = pick_dim(12);
            hr = pick_dim(10);
            area = eff_dim(wr) * eff_dim(hr);
            case ($urandom_range(0, 9))
                7:       count = area + $urandom_range(1, area);
                8, 9:    count = $urandom_range(1, area);
                default: count = area;
            endcase
            if (area > 200)
                count = $urandom_range(1, 60);
            case ($urandom_range(0, 15))
                0:       pat = PAT_FLAT;
                1, 2:    pat = PAT_COL_STEP;
                3, 4:    pat = PAT_ROW_STEP;
                default: pat = PAT_RANDOM;
            endcase
            run_frame(wr, hr, count, pat, $urandom_range(0, 1), $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pix_ch.valid  = 1'b0;
        pix_ch.pixel  = '0;
        grad_ch.ready = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 57;
        pixels_sent   = 0;
        settings_used = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size, start of the first row only
        stream_pixels(40, PAT_RANDOM, 1'b0, '0, RESET_WIDTH, RESET_HEIGHT);

        // directed: single pixel, full-scale steps, zero-sized registers
        run_frame(1, 1, 1, PAT_FLAT, 1'b0, 8'hFF);
        run_frame(3, 3, 9, PAT_COL_STEP, 1'b0, '0);
        run_frame(3, 3, 9, PAT_ROW_STEP, 1'b1, '0);
        run_frame(0, 2, 4, PAT_RANDOM, 1'b0, '0);
        run_frame(2, 0, 2, PAT_FLAT, 1'b0, 8'h00);

        random_frames(180);

        send_idle_pct = 57;
        recv_idle_pct = 23;
        random_frames(180);

        // oversized registers, without idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_frame(4095, 1, 30, PAT_RANDOM, 1'b0, '0);
        run_frame(0, 4095, 24, PAT_RANDOM, 1'b0, '0);
        random_frames(20);

        hold_until_drained();
        repeat (10) @(posedge clk);
        $display("Run covered %0d pixels over %0d frame sizes (1x1, zero and oversized registers)",
                 pixels_sent, settings_used);
        $display("%0d gradient beats checked under three idling mixes", checked_beats);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout with %0d beats outstanding", $time, pending_beats);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/sobel_pkg.sv
hdl/sobel_if.sv
hdl/sobel_linebuf.sv
hdl/sobel_kernel.sv
hdl/sobel_gradient_3x3_replicate.sv
test/sobel_gradient_checker.sv
test/testbench.sv
